FILE: hdl/eul_pkg.sv
// ----------------------------------------------------------------------------
// eul_pkg
// Shared widths, constants and the arctangent table for the Euler angle
// rotation matrix pipeline.
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int ANGLE_W      = 16;
    localparam int ELEM_W       = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam int TRIG_W       = 22;
    localparam int PAIR_W       = 2 * TRIG_W;
    localparam int PART_W       = PAIR_W + 2;
    localparam int SUM_W        = 64;

    localparam logic signed [CW-1:0] PI_S30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_S30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_S30    = 34'sd652032874;

    localparam logic signed [SUM_W-1:0] ROUND_S60 = 64'sd35184372088832;
    localparam logic signed [SUM_W-1:0] ONE_Q14   = 64'sd16384;
    localparam logic signed [SUM_W-1:0] M_ONE_Q14 = -64'sd16384;

    function automatic logic signed [CW-1:0] atan_val(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/eul_cordic.sv
// ----------------------------------------------------------------------------
// eul_cordic
// Pipelined CORDIC giving sine and cosine in Q.20 of a Q3.13 angle, one
// rotation per stage, with range reduction ahead and rounding behind.
// ----------------------------------------------------------------------------
module eul_cordic
    import eul_pkg::*;
(
    input  logic                     clk,
    input  logic                     ce,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]  sin_val,
    output logic signed [TRIG_W-1:0]  cos_val
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 neg_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_next;
    logic                 neg_next;
    logic signed [CW-1:0] xf, yf, xr, yr;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    always_comb
    begin
        z_next   = $signed({angle[ANGLE_W-1], angle, 17'b0});
        neg_next = 1'b0;
        if (z_next > HALF_PI_S30)
        begin
            z_next   = z_next - PI_S30;
            neg_next = 1'b1;
        end
        else if (z_next < -HALF_PI_S30)
        begin
            z_next   = z_next + PI_S30;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]   <= GAIN_S30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_val(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_val(i);
                end
            end
        end
    end

    always_comb
    begin
        xf = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        yf = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        xr = (xf + 34'sd512) >>> 10;
        yr = (yf + 34'sd512) >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cos_reg <= xr[TRIG_W-1:0];
            sin_reg <= yr[TRIG_W-1:0];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: hdl/eul_matmul.sv
// ----------------------------------------------------------------------------
// eul_matmul
// Pipelined product of the three elementary rotations: pair products,
// split triple products, exact sums, then rounding and saturation to Q1.14.
// ----------------------------------------------------------------------------
module eul_matmul
    import eul_pkg::*;
(
    input  logic                     clk,
    input  logic                     ce,
    input  logic signed [TRIG_W-1:0] sx,
    input  logic signed [TRIG_W-1:0] cx,
    input  logic signed [TRIG_W-1:0] sy,
    input  logic signed [TRIG_W-1:0] cy,
    input  logic signed [TRIG_W-1:0] sz,
    input  logic signed [TRIG_W-1:0] cz,
    output logic [9*ELEM_W-1:0]      elems
);

    logic signed [PAIR_W-1:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg;
    logic signed [PAIR_W-1:0] cxcz_reg, sxsz_reg, sxcz_reg, sxcy_reg, cxcy_reg;
    logic signed [TRIG_W-1:0] sy1_reg, sz1_reg, cz1_reg;

    logic signed [PART_W-1:0] a_hi_reg, a_lo_reg, b_hi_reg, b_lo_reg;
    logic signed [PART_W-1:0] c_hi_reg, c_lo_reg, d_hi_reg, d_lo_reg;
    logic signed [PAIR_W-1:0] cycz2_reg, cysz2_reg, cxsz2_reg, cxcz2_reg;
    logic signed [PAIR_W-1:0] sxsz2_reg, sxcz2_reg, sxcy2_reg, cxcy2_reg;
    logic signed [TRIG_W-1:0] sy2_reg;

    logic signed [SUM_W-1:0] sum_reg [0:8];
    logic signed [SUM_W-1:0] sum_next [0:8];
    logic signed [SUM_W-1:0] t_a, t_b, t_c, t_d;
    logic [ELEM_W-1:0] elem_reg [0:8];

    function automatic logic signed [PART_W-1:0] hi_mul(
        input logic signed [PAIR_W-1:0] p,
        input logic signed [TRIG_W-1:0] f
    );
        logic signed [TRIG_W-1:0] ph;
        ph = p[PAIR_W-1:TRIG_W];
        return PART_W'(ph * f);
    endfunction

    function automatic logic signed [PART_W-1:0] lo_mul(
        input logic signed [PAIR_W-1:0] p,
        input logic signed [TRIG_W-1:0] f
    );
        logic signed [TRIG_W:0] pl;
        pl = $signed({1'b0, p[TRIG_W-1:0]});
        return PART_W'(pl * f);
    endfunction

    function automatic logic signed [SUM_W-1:0] join_parts(
        input logic signed [PART_W-1:0] hi,
        input logic signed [PART_W-1:0] lo
    );
        return (SUM_W'(hi) <<< TRIG_W) + SUM_W'(lo);
    endfunction

    function automatic logic signed [SUM_W-1:0] pair_s60(
        input logic signed [PAIR_W-1:0] p
    );
        return SUM_W'(p) <<< 20;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sxsy_reg <= PAIR_W'(sx * sy);
            cxsy_reg <= PAIR_W'(cx * sy);
            cycz_reg <= PAIR_W'(cy * cz);
            cysz_reg <= PAIR_W'(cy * sz);
            cxsz_reg <= PAIR_W'(cx * sz);
            cxcz_reg <= PAIR_W'(cx * cz);
            sxsz_reg <= PAIR_W'(sx * sz);
            sxcz_reg <= PAIR_W'(sx * cz);
            sxcy_reg <= PAIR_W'(sx * cy);
            cxcy_reg <= PAIR_W'(cx * cy);
            sy1_reg  <= sy;
            sz1_reg  <= sz;
            cz1_reg  <= cz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_hi_reg  <= hi_mul(sxsy_reg, cz1_reg);
            a_lo_reg  <= lo_mul(sxsy_reg, cz1_reg);
            b_hi_reg  <= hi_mul(sxsy_reg, sz1_reg);
            b_lo_reg  <= lo_mul(sxsy_reg, sz1_reg);
            c_hi_reg  <= hi_mul(cxsy_reg, cz1_reg);
            c_lo_reg  <= lo_mul(cxsy_reg, cz1_reg);
            d_hi_reg  <= hi_mul(cxsy_reg, sz1_reg);
            d_lo_reg  <= lo_mul(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            sxcy2_reg <= sxcy_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;
        end
    end

    always_comb
    begin
        t_a = join_parts(a_hi_reg, a_lo_reg);
        t_b = join_parts(b_hi_reg, b_lo_reg);
        t_c = join_parts(c_hi_reg, c_lo_reg);
        t_d = join_parts(d_hi_reg, d_lo_reg);
        sum_next[0] = pair_s60(cycz2_reg);
        sum_next[1] = t_a - pair_s60(cxsz2_reg);
        sum_next[2] = t_c + pair_s60(sxsz2_reg);
        sum_next[3] = pair_s60(cysz2_reg);
        sum_next[4] = t_b + pair_s60(cxcz2_reg);
        sum_next[5] = t_d - pair_s60(sxcz2_reg);
        sum_next[6] = -(SUM_W'(sy2_reg) <<< 40);
        sum_next[7] = pair_s60(sxcy2_reg);
        sum_next[8] = pair_s60(cxcy2_reg);
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_elem
        logic signed [SUM_W-1:0] r;
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sum_reg[k] <= sum_next[k];
            end
        end
        always_comb
        begin
            r = (sum_reg[k] + ROUND_S60) >>> 46;
            if (r > ONE_Q14)
            begin
                r = ONE_Q14;
            end
            else if (r < M_ONE_Q14)
            begin
                r = M_ONE_Q14;
            end
        end
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                elem_reg[k] <= r[ELEM_W-1:0];
            end
        end
        assign elems[k*ELEM_W +: ELEM_W] = elem_reg[k];
    end

endmodule

FILE: hdl/euler_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Converts x, y, z Euler angles into the 3x3 rotation matrix Rz*Ry*Rx.
// ----------------------------------------------------------------------------
// The block accepts one angle word per clock unless the output stalls, and
// returns one matrix word per word taken, through 26 stages of the CORDIC
// (range reduction, 24 rotations, rounding) followed by 4 stages of products,
// sums and saturation. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall on the output holds
// every stage in place.
module euler_to_rotation_matrix_top
    import eul_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // angle_x, angle_y, angle_z
    input  logic [47:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20,
    // elem_21, elem_22
    output logic [9*ELEM_W-1:0]  m_tdata
);

    localparam int LATENCY = CORDIC_STEPS + 2 + 4;

    logic                  ce;
    logic [LATENCY-1:0]    valid_reg;
    logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

    assign ce       = !valid_reg[LATENCY-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = valid_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ce)
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], s_tvalid};
        end
    end

    eul_cordic u_cordic_x
    (
        .clk     (clk),
        .ce      (ce),
        .angle   ($signed(s_tdata[15:0])),
        .sin_val (sx),
        .cos_val (cx)
    );

    eul_cordic u_cordic_y
    (
        .clk     (clk),
        .ce      (ce),
        .angle   ($signed(s_tdata[31:16])),
        .sin_val (sy),
        .cos_val (cy)
    );

    eul_cordic u_cordic_z
    (
        .clk     (clk),
        .ce      (ce),
        .angle   ($signed(s_tdata[47:32])),
        .sin_val (sz),
        .cos_val (cz)
    );

    eul_matmul u_matmul
    (
        .clk   (clk),
        .ce    (ce),
        .sx    (sx),
        .cx    (cx),
        .sy    (sy),
        .cy    (cy),
        .sz    (sz),
        .cz    (cz),
        .elems (m_tdata)
    );

endmodule

FILE: hdl/eul_checker.sv
// ----------------------------------------------------------------------------
// eul_checker
// Port-level checks of the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module eul_checker
    import eul_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [47:0]         s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [9*ELEM_W-1:0] m_tdata
);

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output side");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_range_00: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("elem_00 out of range");

    a_range_20: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[111:96]) <= 16'sd16384)
                  && ($signed(m_tdata[111:96]) >= -16'sd16384))
        else $error("elem_20 out of range");

endmodule

bind euler_to_rotation_matrix_top eul_checker u_eul_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
